FILE: sv/tlp_pkg.sv
// Shared types, character codes and helper functions for the telemetry line parser.
// Has no dependencies; the core imports it.
`timescale 1ns / 1ps

package tlp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        MODE_SEARCH,
        MODE_TEMP,
        MODE_ID,
        MODE_POWER,
        MODE_STOP
    } t_mode;

    typedef enum logic [2:0] {
        TPH_START,
        TPH_INT,
        TPH_FRAC1,
        TPH_FRAC2,
        TPH_DONE
    } t_tph;

    localparam logic [2:0] KIND_TEMP  = 3'd0;
    localparam logic [2:0] KIND_SEND  = 3'd1;
    localparam logic [2:0] KIND_CARD  = 3'd2;
    localparam logic [2:0] KIND_POWER = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    localparam logic [4:0] MAX_RESULTS = 5'd21;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_T     = 7'h54;
    localparam logic [6:0] CH_U     = 7'h55;
    localparam logic [6:0] CH_P     = 7'h50;
    localparam logic [6:0] CH_S     = 7'h53;

    localparam logic [3:0] TEMP_BUDGET = 4'd11;
    localparam logic [3:0] ID_DIGITS   = 4'd8;
    localparam logic [3:0] NUM_BUDGET  = 4'd7;
    localparam logic [2:0] NUM_BUDGET2 = 3'd7;

    localparam logic [24:0] TEMP_CEIL    = 25'h1000000;
    localparam logic [24:0] TEMP_NEG_LIM = 25'd8388608;
    localparam logic [24:0] TEMP_POS_LIM = 25'd8388607;
    localparam logic [23:0] CUR_LIMIT    = 24'd2000;
    localparam logic [23:0] VOLT_LIMIT   = 24'd10000;
    localparam logic [23:0] STOP_LIMIT   = 24'd500;
    localparam logic [2:0]  LOG_PERIOD_LAST = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] temperature;
        logic [31:0] card_id;
        logic [10:0] current_ma;
        logic [13:0] battery_mv;
        logic [8:0]  stop_ma;
        logic [31:0] kind_count;
        logic        log_now;
        logic [7:0]  threshold;
        logic [31:0] last_rx_time;
        logic        last;
    } t_result;

    function automatic logic is_mark(input logic [6:0] c);
        return (c == CH_T) || (c == CH_U) || (c == CH_P) || (c == CH_S);
    endfunction

    function automatic logic is_digit(input logic [6:0] c);
        return c inside {[7'h30:7'h39]};
    endfunction

    // Returns 16 for a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [6:0] c);
        logic [4:0] v;
        if (c inside {[7'h30:7'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[7'h41:7'h46], [7'h61:7'h66]}) begin
            v = 5'({1'b0, c[3:0]} + 5'd9);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    function automatic t_mode mark_mode(input logic [6:0] c);
        t_mode m;
        case (c)
            CH_T:    m = MODE_TEMP;
            CH_U:    m = MODE_ID;
            CH_P:    m = MODE_POWER;
            default: m = MODE_STOP;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/tlp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; the read data holds while the read enable is low.
`timescale 1ns / 1ps

module tlp_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/telemetry_line_parser_core.sv
// Telemetry line parser: collects printable bytes into a line and decodes its records.
// Depends on tlp_pkg and on tlp_ram for the line buffer.
// A byte that is not CR or LF is taken whenever the parser is idle. CR or LF on a non-empty
// line stalls the input while the parser reads one stored character per cycle from the line
// buffer (unless a finished request waits for the output register), closes the last field
// and flushes the pending request. A request is presented at the edge at which it leaves
// the pending stage. Reset is synchronous, active low, and clears the line length, counters,
// held values and threshold.
`timescale 1ns / 1ps

module telemetry_line_parser_core #(
    parameter int LINE_CAPACITY = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic [31:0]        i_time_now,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_temp_threshold,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_record_kind,
    output logic signed [23:0] o_temperature,
    output logic [31:0]        o_card_id,
    output logic [10:0]        o_current_ma,
    output logic [13:0]        o_battery_mv,
    output logic [8:0]         o_stop_ma,
    output logic [31:0]        o_kind_count,
    output logic               o_log_now,
    output logic [7:0]         o_threshold_value,
    output logic [31:0]        o_last_rx_time,
    output logic               o_last_record
);

    import tlp_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int LW = $clog2(LINE_CAPACITY + 1);

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    t_tph          r_tph, n_tph;
    logic [LW-1:0] r_line_len;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] idx_next;
    logic [6:0]    r_prev, n_prev;
    logic          r_prev_ok, n_prev_ok;
    logic [31:0]   r_acc, n_acc;
    logic [23:0]   r_acc2, n_acc2;
    logic [3:0]    r_cnt, n_cnt;
    logic [2:0]    r_cnt2, n_cnt2;
    logic          r_second, n_second;
    logic          r_tneg, n_tneg;
    logic [31:0]   r_now;
    logic [7:0]    r_threshold;

    logic [31:0]   r_temp_records, n_temp_records;
    logic [31:0]   r_power_records, n_power_records;
    logic [31:0]   r_stop_cycles, n_stop_cycles;
    logic [2:0]    r_mod5, n_mod5;
    logic [10:0]   r_held_cur, n_held_cur;
    logic [13:0]   r_held_volt, n_held_volt;
    logic [8:0]    r_held_stop, n_held_stop;
    logic [31:0]   r_wd_time, n_wd_time;

    logic [4:0]    r_nres;
    t_result       r_pend;
    logic          r_pend_valid;
    t_result       r_out;
    logic          r_out_valid;
    t_result       new_rec;

    logic          in_acc, cfg_acc, is_eol, printable, line_full;
    logic [6:0]    cur;
    logic [3:0]    dig;
    logic          cur_mark, cur_dig;
    logic [4:0]    cur_hex;
    logic [9:0]    d_x100;
    logic [6:0]    d_x10;
    logic [28:0]   t_int;
    logic [24:0]   t_int_sat;
    logic [23:0]   acc_x10, acc2_x10;
    logic          fin, entry_send, budget_hit;
    logic          rec_ok;
    logic [2:0]    rec_kind;
    logic [23:0]   rec_temp;
    logic [31:0]   rec_card, rec_count;
    logic          rec_log;
    logic [7:0]    rec_thr;
    logic [24:0]   t_mag, t_clip;
    logic [23:0]   temp_word;
    logic          emit_do, push_need, out_busy, adv, last_char;
    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic [6:0]    rd_data;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign is_eol    = (i_rx_byte == CH_LF) || (i_rx_byte == CH_CR);
    assign printable = i_rx_byte inside {[8'd32:8'd126]};
    assign line_full = (r_line_len == LW'(LINE_CAPACITY));
    assign idx_next  = r_idx + LW'(1);
    assign last_char = (idx_next == r_line_len);

    assign wr_en   = in_acc && !is_eol && !line_full && printable;
    assign rd_en   = (r_state == ST_IDLE && in_acc && is_eol)
                  || (r_state == ST_SCAN && adv && !last_char);
    assign rd_addr = (r_state == ST_IDLE) ? '0 : idx_next[AW-1:0];

    tlp_ram #(
        .WIDTH (7),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_line_len[AW-1:0]),
        .i_wr_data (i_rx_byte[6:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cur       = rd_data;
    assign dig       = cur[3:0];
    assign cur_mark  = is_mark(cur);
    assign cur_dig   = is_digit(cur);
    assign cur_hex   = hex_value(cur);
    assign d_x100    = 10'(dig) * 10'd100;
    assign d_x10     = 7'(dig) * 7'd10;
    assign t_int     = 29'({r_acc[24:0], 3'b000}) + 29'({r_acc[24:0], 1'b0}) + 29'(d_x100);
    assign t_int_sat = (t_int > 29'(TEMP_CEIL)) ? TEMP_CEIL : t_int[24:0];
    assign acc_x10   = 24'({r_acc[20:0], 3'b000}) + 24'({r_acc[22:0], 1'b0}) + 24'(dig);
    assign acc2_x10  = 24'({r_acc2[20:0], 3'b000}) + 24'({r_acc2[22:0], 1'b0}) + 24'(dig);

    // One character of the line per step: mark search or field accumulation; ST_FIN closes the open field.
    always_comb begin
        n_mode     = r_mode;
        n_tph      = r_tph;
        n_prev     = r_prev;
        n_prev_ok  = r_prev_ok;
        n_acc      = r_acc;
        n_acc2     = r_acc2;
        n_cnt      = r_cnt;
        n_cnt2     = r_cnt2;
        n_second   = r_second;
        n_tneg     = r_tneg;
        fin        = 1'b0;
        entry_send = 1'b0;
        budget_hit = 1'b0;
        if (r_state == ST_FIN) begin
            fin    = (r_mode != MODE_SEARCH);
            n_mode = MODE_SEARCH;
        end else if (r_state == ST_SCAN) begin
            if (r_mode == MODE_SEARCH) begin
                if (r_prev_ok && cur == CH_COLON && is_mark(r_prev)) begin
                    n_mode     = mark_mode(r_prev);
                    n_prev_ok  = 1'b0;
                    n_acc      = '0;
                    n_acc2     = '0;
                    n_cnt      = '0;
                    n_cnt2     = '0;
                    n_second   = 1'b0;
                    n_tneg     = 1'b0;
                    n_tph      = TPH_START;
                    entry_send = (r_prev == CH_U);
                end else begin
                    n_prev    = cur;
                    n_prev_ok = 1'b1;
                end
            end else if (cur_mark) begin
                // The mark closes the field and opens the next search pair.
                fin       = 1'b1;
                n_mode    = MODE_SEARCH;
                n_prev    = cur;
                n_prev_ok = 1'b1;
            end else begin
                case (r_mode)
                    MODE_TEMP: begin
                        if (cur_dig || cur == CH_DOT || cur == CH_MINUS) begin
                            n_cnt = r_cnt + 4'd1;
                            case (r_tph)
                                TPH_START: begin
                                    if (cur == CH_MINUS) begin
                                        n_tneg = 1'b1;
                                        n_tph  = TPH_INT;
                                    end else if (cur_dig) begin
                                        n_acc = 32'(d_x100);
                                        n_tph = TPH_INT;
                                    end else begin
                                        n_tph = TPH_FRAC1;
                                    end
                                end
                                TPH_INT: begin
                                    if (cur_dig) begin
                                        n_acc = 32'(t_int_sat);
                                    end else if (cur == CH_DOT) begin
                                        n_tph = TPH_FRAC1;
                                    end else begin
                                        n_tph = TPH_DONE;
                                    end
                                end
                                TPH_FRAC1: begin
                                    if (cur_dig) begin
                                        n_acc = 32'(r_acc[24:0] + 25'(d_x10));
                                        n_tph = TPH_FRAC2;
                                    end else begin
                                        n_tph = TPH_DONE;
                                    end
                                end
                                TPH_FRAC2: begin
                                    if (cur_dig) begin
                                        n_acc = 32'(r_acc[24:0] + 25'(dig));
                                    end
                                    n_tph = TPH_DONE;
                                end
                                default: ;
                            endcase
                        end
                        budget_hit = (n_cnt == TEMP_BUDGET);
                    end
                    MODE_ID: begin
                        if (!cur_hex[4]) begin
                            n_acc = {r_acc[27:0], cur_hex[3:0]};
                            n_cnt = r_cnt + 4'd1;
                        end
                        budget_hit = (n_cnt == ID_DIGITS);
                    end
                    MODE_POWER: begin
                        if (cur == CH_COMMA) begin
                            n_second = 1'b1;
                        end else if (cur_dig) begin
                            if (!r_second) begin
                                n_acc = 32'(acc_x10);
                                n_cnt = r_cnt + 4'd1;
                            end else begin
                                n_acc2 = acc2_x10;
                                n_cnt2 = r_cnt2 + 3'd1;
                            end
                        end
                        budget_hit = (n_cnt == NUM_BUDGET) || (n_cnt2 == NUM_BUDGET2);
                    end
                    MODE_STOP: begin
                        if (cur_dig) begin
                            n_acc = 32'(acc_x10);
                            n_cnt = r_cnt + 4'd1;
                        end
                        budget_hit = (n_cnt == NUM_BUDGET);
                    end
                    default: ;
                endcase
                if (budget_hit) begin
                    fin       = 1'b1;
                    n_mode    = MODE_SEARCH;
                    n_prev_ok = 1'b0;
                end
            end
        end
    end

    assign t_mag     = n_acc[24:0];
    assign t_clip    = (t_mag > TEMP_NEG_LIM) ? TEMP_NEG_LIM : t_mag;
    assign temp_word = n_tneg ? 24'(~t_clip[23:0] + 24'd1)
                              : ((t_mag > TEMP_POS_LIM) ? TEMP_POS_LIM[23:0] : t_mag[23:0]);

    // Record checks and the state that a completed record updates.
    always_comb begin
        rec_ok          = 1'b0;
        rec_kind        = KIND_TEMP;
        rec_temp        = '0;
        rec_card        = '0;
        rec_count       = '0;
        rec_log         = 1'b0;
        rec_thr         = '0;
        n_temp_records  = r_temp_records;
        n_power_records = r_power_records;
        n_stop_cycles   = r_stop_cycles;
        n_mod5          = r_mod5;
        n_held_cur      = r_held_cur;
        n_held_volt     = r_held_volt;
        n_held_stop     = r_held_stop;
        n_wd_time       = r_wd_time;
        if (fin) begin
            case (r_mode)
                MODE_TEMP: begin
                    if (n_cnt != 4'd0) begin
                        rec_ok         = 1'b1;
                        rec_kind       = KIND_TEMP;
                        n_temp_records = r_temp_records + 32'd1;
                        n_wd_time      = r_now;
                        rec_temp       = temp_word;
                        rec_count      = n_temp_records;
                    end
                end
                MODE_ID: begin
                    if (n_cnt == ID_DIGITS) begin
                        rec_ok    = 1'b1;
                        rec_kind  = KIND_CARD;
                        n_wd_time = r_now;
                        rec_card  = n_acc;
                    end
                end
                MODE_POWER: begin
                    if (n_cnt != 4'd0 && n_cnt2 != 3'd0 && n_acc[23:0] < CUR_LIMIT
                            && n_acc2 < VOLT_LIMIT) begin
                        rec_ok          = 1'b1;
                        rec_kind        = KIND_POWER;
                        n_held_cur      = n_acc[10:0];
                        n_held_volt     = n_acc2[13:0];
                        n_power_records = r_power_records + 32'd1;
                        n_wd_time       = r_now;
                        rec_count       = n_power_records;
                    end
                end
                MODE_STOP: begin
                    if (n_cnt != 4'd0 && n_acc[23:0] < STOP_LIMIT) begin
                        rec_ok        = 1'b1;
                        rec_kind      = KIND_STOP;
                        n_held_stop   = n_acc[8:0];
                        n_stop_cycles = r_stop_cycles + 32'd1;
                        // The count wraps to zero, which is itself a multiple of five.
                        n_mod5        = (r_mod5 == LOG_PERIOD_LAST || r_stop_cycles == '1)
                                        ? 3'd0 : r_mod5 + 3'd1;
                        n_wd_time     = r_now;
                        rec_count     = n_stop_cycles;
                        rec_log       = (n_mod5 == 3'd0);
                    end
                end
                default: ;
            endcase
        end
        if (entry_send) begin
            rec_kind = KIND_SEND;
            rec_thr  = r_threshold;
        end
        new_rec.kind         = rec_kind;
        new_rec.temperature  = rec_temp;
        new_rec.card_id      = rec_card;
        new_rec.current_ma   = n_held_cur;
        new_rec.battery_mv   = n_held_volt;
        new_rec.stop_ma      = n_held_stop;
        new_rec.kind_count   = rec_count;
        new_rec.log_now      = rec_log;
        new_rec.threshold    = rec_thr;
        new_rec.last_rx_time = n_wd_time;
        new_rec.last         = 1'b0;
    end

    // The newest record waits in the pending stage until the next one, or the end of the
    // line, tells whether it is the last of the line.
    assign out_busy  = r_out_valid && i_out_stall;
    assign emit_do   = (entry_send || rec_ok) && (r_nres < MAX_RESULTS);
    assign push_need = (r_state == ST_FLUSH) ? r_pend_valid
                                             : (emit_do && r_pend_valid);
    assign adv       = !(push_need && out_busy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_eol && r_line_len != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (adv && last_char) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (adv) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != ST_IDLE);
        o_cfg_ready       = 1'b1;
        o_out_valid       = r_out_valid;
        o_record_kind     = r_out.kind;
        o_temperature     = $signed(r_out.temperature);
        o_card_id         = r_out.card_id;
        o_current_ma      = r_out.current_ma;
        o_battery_mv      = r_out.battery_mv;
        o_stop_ma         = r_out.stop_ma;
        o_kind_count      = r_out.kind_count;
        o_log_now         = r_out.log_now;
        o_threshold_value = r_out.threshold;
        o_last_rx_time    = r_out.last_rx_time;
        o_last_record     = r_out.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_mode          <= MODE_SEARCH;
            r_tph           <= TPH_START;
            r_line_len      <= '0;
            r_idx           <= '0;
            r_prev_ok       <= 1'b0;
            r_threshold     <= '0;
            r_temp_records  <= '0;
            r_power_records <= '0;
            r_stop_cycles   <= '0;
            r_mod5          <= '0;
            r_held_cur      <= '0;
            r_held_volt     <= '0;
            r_held_stop     <= '0;
            r_wd_time       <= '0;
            r_nres          <= '0;
            r_pend_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_threshold <= i_temp_threshold;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (is_eol) begin
                            r_now        <= i_time_now;
                            r_idx        <= '0;
                            r_mode       <= MODE_SEARCH;
                            r_prev_ok    <= 1'b0;
                            r_nres       <= '0;
                            r_pend_valid <= 1'b0;
                        end else if (line_full) begin
                            r_line_len <= '0;
                        end else if (printable) begin
                            r_line_len <= r_line_len + LW'(1);
                        end
                    end
                end
                ST_SCAN, ST_FIN: begin
                    if (adv) begin
                        r_mode          <= n_mode;
                        r_tph           <= n_tph;
                        r_prev          <= n_prev;
                        r_prev_ok       <= n_prev_ok;
                        r_acc           <= n_acc;
                        r_acc2          <= n_acc2;
                        r_cnt           <= n_cnt;
                        r_cnt2          <= n_cnt2;
                        r_second        <= n_second;
                        r_tneg          <= n_tneg;
                        r_temp_records  <= n_temp_records;
                        r_power_records <= n_power_records;
                        r_stop_cycles   <= n_stop_cycles;
                        r_mod5          <= n_mod5;
                        r_held_cur      <= n_held_cur;
                        r_held_volt     <= n_held_volt;
                        r_held_stop     <= n_held_stop;
                        r_wd_time       <= n_wd_time;
                        if (r_state == ST_SCAN && !last_char) begin
                            r_idx <= idx_next;
                        end
                        if (emit_do) begin
                            r_pend       <= new_rec;
                            r_pend_valid <= 1'b1;
                            r_nres       <= r_nres + 5'd1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (adv) begin
                        r_line_len   <= '0;
                        r_pend_valid <= 1'b0;
                    end
                end
                default: ;
            endcase

            // The last flag is the lowest bit of the packed request.
            if (adv && push_need) begin
                r_out       <= {r_pend[$bits(t_result)-1:1], r_state == ST_FLUSH};
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= MAX_RESULTS)
        else $error("result count per line exceeded its limit");

    a_idx_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx < r_line_len))
        else $error("scan index ran past the stored line");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= LW'(LINE_CAPACITY))
        else $error("line length exceeded the buffer capacity");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && adv) |=> (r_state == ST_IDLE && !r_pend_valid))
        else $error("pending request left behind at the end of a line");

endmodule
